// ----- rtl/core/qrs_pkg.sv -----
// Shared types and constants of the quadratic root solver core.
package qrs_pkg;

   // input and result field widths
   localparam int COEF_W    = 16;
   localparam int FRAC_BITS = 16;
   localparam int DISC_W    = 34;
   localparam int ROOT_W    = 40;
   localparam int CLASS_W   = 2;

   // square root: radicand is the non-negative discriminant shifted by 2*FRAC_BITS
   localparam int RAD_W     = DISC_W - 1 + 2 * FRAC_BITS;
   localparam int SQ_BITS   = (RAD_W + 1) / 2;
   localparam int SQ_REM_W  = RAD_W + 1;

   // divider: numerator magnitude and divisor magnitude
   localparam int NUM_W     = SQ_BITS + 2;
   localparam int DEN_W     = COEF_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // root class codes
   localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_DOUBLE = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_TWO    = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_DEGEN  = 2'd3;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_quad;
      logic signed [COEF_W-1:0] coef_lin;
      logic signed [COEF_W-1:0] coef_const;
   } qrs_req_type;

   typedef struct packed {
      logic signed [DISC_W-1:0] discriminant;
      logic [CLASS_W-1:0]       root_class;
      logic signed [ROOT_W-1:0] root_plus;
      logic signed [ROOT_W-1:0] root_minus;
   } qrs_rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic signed [DISC_W-1:0] disc;
      logic [CLASS_W-1:0]       cls;
      logic signed [COEF_W-1:0] coef_quad;
      logic signed [COEF_W-1:0] coef_lin;
   } qrs_job_type;

endpackage

// ----- rtl/core/quadratic_root_solver_core.sv -----
// Quadratic root solver core: front classifier, queue and pipelined root back end.
// The path from accepted word to result runs through the 33-stage square root and the
// 35-stage dividers, one bit per stage.
// Throughput: one word per cycle; busy rises only if the queue fills.
// Reset (synchronous, active high) empties the pipeline and queue; no results pend.
// The receiver cannot stall: each result shows on rsp_valid for exactly one cycle.
module quadratic_root_solver_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qrs_pkg::qrs_req_type req_word,
   output logic                 rsp_valid,
   output qrs_pkg::qrs_rsp_type rsp_word
);
   import qrs_pkg::*;

   logic        q_push, q_full, q_not_empty, q_pop;
   qrs_job_type push_job, pop_job;

   // accept and classify
   qrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   // decouple front from back
   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_job   (pop_job)
   );

   // compute roots
   qrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule

// ----- rtl/core/qrs_front.sv -----
// Front end: accepts coefficient words, forms the discriminant and classifies them.
module qrs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  qrs_pkg::qrs_req_type req_word,
   input  logic                q_full,
   output logic                q_push,
   output qrs_pkg::qrs_job_type q_job
);
   import qrs_pkg::*;

   logic                       s1_valid_ff;
   logic signed [COEF_W-1:0]   s1_a_ff, s1_b_ff;
   logic signed [2*COEF_W-1:0] s1_bb_ff, s1_ac_ff;
   logic                       s2_valid_ff;
   qrs_job_type                s2_job_ff, s2_job_in;
   logic signed [DISC_W-1:0]   disc_in;
   logic                       stall2, stall1, accept;

   // hold stages while the queue is full
   assign stall2 = s2_valid_ff & q_full;
   assign stall1 = s1_valid_ff & stall2;
   assign busy   = stall1;
   assign accept = start & ~busy;
   assign q_push = s2_valid_ff & ~q_full;
   assign q_job  = s2_job_ff;

   // discriminant and class from the registered products
   always_comb begin
      disc_in = DISC_W'(s1_bb_ff) - (DISC_W'(s1_ac_ff) <<< 2);
      s2_job_in.disc      = disc_in;
      s2_job_in.coef_quad = s1_a_ff;
      s2_job_in.coef_lin  = s1_b_ff;
      priority if (s1_a_ff == '0) begin
         s2_job_in.cls = CLS_DEGEN;
      end else if (disc_in[DISC_W-1]) begin
         s2_job_in.cls = CLS_NONE;
      end else if (disc_in == '0) begin
         s2_job_in.cls = CLS_DOUBLE;
      end else begin
         s2_job_in.cls = CLS_TWO;
      end
   end

   // advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (!stall1) begin
            s1_valid_ff <= accept;
         end
         if (!stall2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall1) begin
         s1_a_ff  <= req_word.coef_quad;
         s1_b_ff  <= req_word.coef_lin;
         s1_bb_ff <= (2*COEF_W)'(req_word.coef_lin) * (2*COEF_W)'(req_word.coef_lin);
         s1_ac_ff <= (2*COEF_W)'(req_word.coef_quad) * (2*COEF_W)'(req_word.coef_const);
      end
      if (!stall2) begin
         s2_job_ff <= s2_job_in;
      end
   end

endmodule

// ----- rtl/core/qrs_queue.sv -----
// Short queue of classified words between front and back.
module qrs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qrs_pkg::qrs_job_type push_job,
   output logic                 full,
   output logic                 not_empty,
   input  logic                 pop,
   output qrs_pkg::qrs_job_type pop_job
);
   import qrs_pkg::*;

   qrs_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, tail_ff;
   logic [QPTR_W:0]   count_ff;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = slot_ff[head_ff];

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/qrs_back.sv -----
// Back end: pipelined square root, two pipelined dividers and result register.
module qrs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  qrs_pkg::qrs_job_type q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output qrs_pkg::qrs_rsp_type rsp_word
);
   import qrs_pkg::*;

   // square root stages
   logic                     sq_valid_ff [SQ_BITS+1];
   logic [SQ_REM_W-1:0]      sq_rem_ff   [SQ_BITS+1];
   logic [SQ_BITS-1:0]       sq_root_ff  [SQ_BITS+1];
   qrs_job_type              sq_job_ff   [SQ_BITS+1];

   // numerator stage
   logic                     nu_valid_ff;
   logic [NUM_W-1:0]         nu_np_ff, nu_nm_ff;
   logic [DEN_W-1:0]         nu_dv_ff;
   logic                     nu_negp_ff, nu_negm_ff;
   logic signed [DISC_W-1:0] nu_disc_ff;
   logic [CLASS_W-1:0]       nu_cls_ff;
   logic signed [NUM_W:0]    base, np, nm;
   logic signed [DEN_W:0]    den;

   // divider stages
   logic                     dv_valid_ff [NUM_W+1];
   logic [NUM_W-1:0]         dv_np_ff    [NUM_W+1];
   logic [NUM_W-1:0]         dv_nm_ff    [NUM_W+1];
   logic [NUM_W-1:0]         dv_qp_ff    [NUM_W+1];
   logic [NUM_W-1:0]         dv_qm_ff    [NUM_W+1];
   logic [DEN_W-1:0]         dv_rp_ff    [NUM_W+1];
   logic [DEN_W-1:0]         dv_rm_ff    [NUM_W+1];
   logic [DEN_W-1:0]         dv_dv_ff    [NUM_W+1];
   logic                     dv_negp_ff  [NUM_W+1];
   logic                     dv_negm_ff  [NUM_W+1];
   logic signed [DISC_W-1:0] dv_disc_ff  [NUM_W+1];
   logic [CLASS_W-1:0]       dv_cls_ff   [NUM_W+1];

   // output register
   logic                     out_valid_ff;
   qrs_rsp_type              out_word_ff, out_word_in;
   logic                     has_roots;
   logic signed [ROOT_W-1:0] qp_s, qm_s;

   // drain the queue every cycle that it holds a word
   assign q_pop = q_not_empty;

   // load the radicand
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      sq_job_ff[0]  <= q_job;
      sq_root_ff[0] <= '0;
      if (q_job.cls == CLS_DOUBLE || q_job.cls == CLS_TWO) begin
         sq_rem_ff[0] <= {1'b0, q_job.disc[DISC_W-2:0], {(2*FRAC_BITS){1'b0}}};
      end else begin
         sq_rem_ff[0] <= '0;
      end
   end

   // one root bit per stage, most significant first
   for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
      localparam int KB = SQ_BITS - 1 - j;
      logic [SQ_REM_W-1:0] trial;
      logic                fits;

      always_comb begin
         trial = (SQ_REM_W'(sq_root_ff[j]) << (KB + 1)) | (SQ_REM_W'(1) << (2 * KB));
         fits  = (sq_rem_ff[j] >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[j+1] <= 1'b0;
         end else begin
            sq_valid_ff[j+1] <= sq_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         sq_job_ff[j+1]  <= sq_job_ff[j];
         sq_rem_ff[j+1]  <= fits ? (sq_rem_ff[j] - trial) : sq_rem_ff[j];
         sq_root_ff[j+1] <= sq_root_ff[j] | (SQ_BITS'(fits) << KB);
      end
   end

   // form numerators -b*2^F +/- s and the divisor 2a
   always_comb begin
      base = -((NUM_W+1)'(sq_job_ff[SQ_BITS].coef_lin) <<< FRAC_BITS);
      np   = base + $signed((NUM_W+1)'(sq_root_ff[SQ_BITS]));
      nm   = base - $signed((NUM_W+1)'(sq_root_ff[SQ_BITS]));
      den  = (DEN_W+1)'(sq_job_ff[SQ_BITS].coef_quad) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nu_valid_ff <= 1'b0;
      end else begin
         nu_valid_ff <= sq_valid_ff[SQ_BITS];
      end
   end

   always_ff @(posedge clock) begin
      nu_np_ff   <= np[NUM_W] ? NUM_W'(-np) : NUM_W'(np);
      nu_nm_ff   <= nm[NUM_W] ? NUM_W'(-nm) : NUM_W'(nm);
      nu_dv_ff   <= den[DEN_W] ? DEN_W'(-den) : DEN_W'(den);
      nu_negp_ff <= np[NUM_W] ^ den[DEN_W];
      nu_negm_ff <= nm[NUM_W] ^ den[DEN_W];
      nu_disc_ff <= sq_job_ff[SQ_BITS].disc;
      nu_cls_ff  <= sq_job_ff[SQ_BITS].cls;
   end

   // enter the dividers
   always_comb begin
      dv_valid_ff[0] = nu_valid_ff;
      dv_np_ff[0]    = nu_np_ff;
      dv_nm_ff[0]    = nu_nm_ff;
      dv_qp_ff[0]    = '0;
      dv_qm_ff[0]    = '0;
      dv_rp_ff[0]    = '0;
      dv_rm_ff[0]    = '0;
      dv_dv_ff[0]    = nu_dv_ff;
      dv_negp_ff[0]  = nu_negp_ff;
      dv_negm_ff[0]  = nu_negm_ff;
      dv_disc_ff[0]  = nu_disc_ff;
      dv_cls_ff[0]   = nu_cls_ff;
   end

   // one quotient bit per stage for both roots
   for (genvar j = 0; j < NUM_W; j++) begin : g_div
      localparam int QB = NUM_W - 1 - j;
      logic [DEN_W:0] shp, shm;
      logic           gep, gem;

      always_comb begin
         shp = {dv_rp_ff[j], dv_np_ff[j][QB]};
         shm = {dv_rm_ff[j], dv_nm_ff[j][QB]};
         gep = (shp >= {1'b0, dv_dv_ff[j]});
         gem = (shm >= {1'b0, dv_dv_ff[j]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         dv_np_ff[j+1]   <= dv_np_ff[j];
         dv_nm_ff[j+1]   <= dv_nm_ff[j];
         dv_qp_ff[j+1]   <= dv_qp_ff[j] | (NUM_W'(gep) << QB);
         dv_qm_ff[j+1]   <= dv_qm_ff[j] | (NUM_W'(gem) << QB);
         dv_rp_ff[j+1]   <= gep ? DEN_W'(shp - {1'b0, dv_dv_ff[j]}) : DEN_W'(shp);
         dv_rm_ff[j+1]   <= gem ? DEN_W'(shm - {1'b0, dv_dv_ff[j]}) : DEN_W'(shm);
         dv_dv_ff[j+1]   <= dv_dv_ff[j];
         dv_negp_ff[j+1] <= dv_negp_ff[j];
         dv_negm_ff[j+1] <= dv_negm_ff[j];
         dv_disc_ff[j+1] <= dv_disc_ff[j];
         dv_cls_ff[j+1]  <= dv_cls_ff[j];
      end
   end

   // apply signs, drop roots where there are none
   always_comb begin
      has_roots = (dv_cls_ff[NUM_W] == CLS_DOUBLE) || (dv_cls_ff[NUM_W] == CLS_TWO);
      qp_s = dv_negp_ff[NUM_W] ? -$signed(ROOT_W'(dv_qp_ff[NUM_W]))
                               : $signed(ROOT_W'(dv_qp_ff[NUM_W]));
      qm_s = dv_negm_ff[NUM_W] ? -$signed(ROOT_W'(dv_qm_ff[NUM_W]))
                               : $signed(ROOT_W'(dv_qm_ff[NUM_W]));
      out_word_in.discriminant = dv_disc_ff[NUM_W];
      out_word_in.root_class   = dv_cls_ff[NUM_W];
      out_word_in.root_plus    = has_roots ? qp_s : '0;
      out_word_in.root_minus   = has_roots ? qm_s : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ----- tb/sv/tb_quadratic_root_solver_core.sv -----
// Self-checking testbench for the quadratic root solver core.
module tb_quadratic_root_solver_core;
   import qrs_pkg::*;

   typedef struct {
      qrs_req_type word;
      int          gap;
      bit          drain;
   } coef_set_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   qrs_req_type req_word = '0;
   logic        rsp_valid;
   qrs_rsp_type rsp_word;

   coef_set_type pending_sets[$];
   qrs_rsp_type  expected_roots[$];
   int           mismatch_count = 0;
   int           wait_count = 0;
   bit           idle_mode = 1'b0;

   quadratic_root_solver_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // free-running clock
   always #5 clock = ~clock;

   // compute discriminant, class and fixed-point roots of one coefficient set
   function automatic qrs_rsp_type solve_roots(qrs_req_type w);
      longint      qa, lb, kc, disc, num_p, num_m;
      logic [127:0] rad, r, t;
      qrs_rsp_type res;
      qa = longint'(w.coef_quad);
      lb = longint'(w.coef_lin);
      kc = longint'(w.coef_const);
      disc = lb * lb - 4 * qa * kc;
      res = '0;
      res.discriminant = disc[DISC_W-1:0];
      if (qa == 0) begin
         res.root_class = CLS_DEGEN;
      end else if (disc < 0) begin
         res.root_class = CLS_NONE;
      end else begin
         res.root_class = (disc == 0) ? CLS_DOUBLE : CLS_TWO;
         // truncated square root of the scaled discriminant, bit by bit
         rad = 128'(disc) << (2 * FRAC_BITS);
         r = '0;
         for (int k = 63; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= rad)
               r = t;
         end
         num_p = -lb * (longint'(1) << FRAC_BITS) + longint'(r[63:0]);
         num_m = -lb * (longint'(1) << FRAC_BITS) - longint'(r[63:0]);
         num_p = num_p / (2 * qa);
         num_m = num_m / (2 * qa);
         res.root_plus  = num_p[ROOT_W-1:0];
         res.root_minus = num_m[ROOT_W-1:0];
      end
      return res;
   endfunction

   task automatic report_field(string field, logic [63:0] exp_val, logic [63:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0h got %0h", $realtime, field, exp_val, act_val);
   endtask

   function automatic int draw_gap();
      if ($urandom_range(0, 99) < 3)
         idle_mode = ~idle_mode;
      return idle_mode ? int'($urandom_range(0, 13)) : 0;
   endfunction

   task automatic add_set(int qa, int lb, int kc, bit drain = 1'b0);
      coef_set_type cs;
      cs.word.coef_quad  = qa[COEF_W-1:0];
      cs.word.coef_lin   = lb[COEF_W-1:0];
      cs.word.coef_const = kc[COEF_W-1:0];
      cs.gap   = draw_gap();
      cs.drain = drain;
      pending_sets.push_back(cs);
   endtask

   // driver: record accepted word, then present the next one after its gap
   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_roots.push_back(solve_roots(req_word));
            next_start = 1'b0;
         end
         if (!next_start && pending_sets.size() > 0) begin
            if (wait_count < pending_sets[0].gap) begin
               wait_count++;
            end else if (!(pending_sets[0].drain && expected_roots.size() > 0)) begin
               req_word   <= pending_sets[0].word;
               next_start = 1'b1;
               wait_count = 0;
               void'(pending_sets.pop_front());
            end
         end
         start <= next_start;
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      qrs_rsp_type exp_w;
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            report_field("unexpected result", '0, 64'(rsp_word.discriminant));
         end else begin
            exp_w = expected_roots.pop_front();
            if (rsp_word.discriminant !== exp_w.discriminant)
               report_field("discriminant", 64'(exp_w.discriminant),
                            64'(rsp_word.discriminant));
            if (rsp_word.root_class !== exp_w.root_class)
               report_field("root_class", 64'(exp_w.root_class), 64'(rsp_word.root_class));
            if (rsp_word.root_plus !== exp_w.root_plus)
               report_field("root_plus", 64'(exp_w.root_plus), 64'(rsp_word.root_plus));
            if (rsp_word.root_minus !== exp_w.root_minus)
               report_field("root_minus", 64'(exp_w.root_minus), 64'(rsp_word.root_minus));
         end
      end
   end

   // stimulus and end of run
   initial begin
      int qa, m, kind;
      // directed: degenerate, extremes, each class
      add_set(0, 0, 0);
      add_set(0, 5, -7);
      add_set(0, -32768, 32767);
      add_set(1, 2, 1);
      add_set(1, -2, 1);
      add_set(16384, -32768, 16384);
      add_set(-1, 0, 0);
      add_set(1, 0, 1);
      add_set(1, 0, -1);
      add_set(1, -3, 2);
      add_set(-32768, 0, -32768);
      add_set(-32768, -32768, 32767);
      add_set(32767, 32767, -32768);
      add_set(-32768, 32767, 32767);
      add_set(32767, -32768, -32768);
      add_set(1, 32767, 0);
      add_set(-1, -32768, 0);
      add_set(3, 7, -11);
      add_set(-5, 1, 9);
      add_set(32767, 0, 0, 1'b1);
      // random: full range, small values and forced double roots
      for (int i = 0; i < 1430; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            add_set(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                    int'($urandom_range(0, 65535)), (i % 300) == 299);
         end else if (kind < 8) begin
            add_set(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 80)) - 40,
                    int'($urandom_range(0, 40)) - 20, (i % 300) == 299);
         end else begin
            qa = int'($urandom_range(1, 100)) * (($urandom_range(0, 1) == 1) ? -1 : 1);
            m  = int'($urandom_range(0, 30)) - 15;
            add_set(qa, -2 * qa * m, qa * m * m, (i % 300) == 299);
         end
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // hold until every word is sent and every result is back
      while (pending_sets.size() > 0 || start || expected_roots.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_roots.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
